### hw/rtl/msk_pkg.sv
// ----------------------------------------------------------------------------
// msk_pkg: shared types and constants of the multichannel scalar Kalman filter
// Word widths, the per-channel store entry and the status of the serial units.
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int WORD_W = 32;  // measurement, noise, estimate and variance
  localparam int CHAN_W = 4;   // channel field on the ports

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic signed [WORD_W-1:0] est;
    logic        [WORD_W-1:0] pvar;
  } msk_entry_t;

  // Status reported by a bit-serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### hw/rtl/multichannel_scalar_kalman.sv
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman: scalar random-walk Kalman filter for many sensors
// One shared bit-serial datapath updates the estimate and variance of the
// channel named by each item, in Q-format fixed point.
//
// Input channel: an item (channel, measurement, process and measurement noise)
// is taken when in_valid is high and in_stall is low. Items whose channel is
// not below CHANNELS are dropped without a result.
// Result channel: one item (channel_out, estimate, variance) per kept input,
// held in the output register while out_stall is high.
// Processing: an accepted item passes through the memory read, setup, the
// serial gain divider, the serial multiplier and the write-back in turn. The
// divider forms FRAC_BITS + 1 quotient bits and the multiplier steps through
// FRAC_BITS gain bits, one bit at a time. The next item is taken only after
// write-back, also while a result still waits; a finished update waits for
// the output register when it is occupied.
// Reset: all channels are marked unseen; the first item on a channel starts
// the filter at its measurement with a variance of one.
// ----------------------------------------------------------------------------
module multichannel_scalar_kalman import msk_pkg::*; #(
  parameter int CHANNELS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHAN_W-1:0]        in_channel,
  input  logic signed [WORD_W-1:0] in_measurement,
  input  logic [WORD_W-1:0]        in_process_noise,
  input  logic [WORD_W-1:0]        in_measure_noise,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAN_W-1:0]        out_channel_out,
  output logic signed [WORD_W-1:0] out_estimate,
  output logic [WORD_W-1:0]        out_variance
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [WORD_W-1:0] VAR_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W+2:0] EST_MAX = {4'b0000, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W+2:0] EST_MIN = {4'b1111, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PREP,
    S_DEN,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CHAN_W-1:0]        ch_r;
  logic signed [WORD_W-1:0] z_r;
  logic [WORD_W-1:0]        q_r;
  logic [WORD_W-1:0]        rn_r;
  logic signed [WORD_W-1:0] x_r;
  logic [WORD_W-1:0]        pp_r;
  logic signed [WORD_W:0]   diff_r;

  logic                     out_valid_r;
  logic [CHAN_W-1:0]        out_channel_r;
  logic signed [WORD_W-1:0] out_estimate_r;
  logic [WORD_W-1:0]        out_variance_r;

  logic                     in_take;
  logic                     in_range;
  logic                     out_free;

  msk_entry_t               rd_data;
  logic                     rd_seen;
  msk_entry_t               wr_data;
  logic                     wr_en;

  logic signed [WORD_W-1:0] x_cur;
  logic [WORD_W-1:0]        p_cur;
  logic [WORD_W:0]          pp_sum;
  logic [WORD_W:0]          den;

  logic [FRAC_BITS:0]       gain;
  unit_status_t             div_st;
  logic signed [WORD_W+1:0] corr;
  logic [WORD_W-1:0]        kpp;
  unit_status_t             mul_st;

  logic signed [WORD_W+2:0] est_sum;
  logic signed [WORD_W-1:0] est_new;
  logic [WORD_W-1:0]        var_new;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign in_range = (32'(in_channel) < CHANNELS);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_en    = (state_r == S_DONE) && out_free;

  msk_store #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == S_READ),
    .rd_addr (CH_W'(ch_r)),
    .rd_data (rd_data),
    .rd_seen (rd_seen),
    .wr_en   (wr_en),
    .wr_addr (CH_W'(ch_r)),
    .wr_data (wr_data)
  );

  msk_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DEN),
    .pp     (pp_r),
    .den    (den),
    .gain   (gain),
    .status (div_st)
  );

  msk_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  ((state_r == S_DIV) && div_st.done),
    .gain   (gain),
    .diff   (diff_r),
    .pp     (pp_r),
    .corr   (corr),
    .kpp    (kpp),
    .status (mul_st)
  );

  // A channel seen for the first time starts from its own measurement.
  always_comb begin
    x_cur  = rd_seen ? rd_data.est  : z_r;
    p_cur  = rd_seen ? rd_data.pvar : VAR_ONE;
    pp_sum = {1'b0, p_cur} + {1'b0, q_r};
    den    = {1'b0, pp_r} + {1'b0, rn_r};
  end

  always_comb begin
    est_sum = {{3{x_r[WORD_W-1]}}, x_r} + {corr[WORD_W+1], corr};
    if (est_sum > EST_MAX) begin
      est_new = WORD_W'(EST_MAX);
    end else if (est_sum < EST_MIN) begin
      est_new = WORD_W'(EST_MIN);
    end else begin
      est_new = est_sum[WORD_W-1:0];
    end
    var_new = pp_r - kpp;
    wr_data = '{est: est_new, pvar: var_new};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_take && in_range) state_nxt = S_READ;
      S_READ: state_nxt = S_PREP;
      S_PREP: state_nxt = S_DEN;
      S_DEN:  state_nxt = S_DIV;
      S_DIV:  if (div_st.done) state_nxt = S_MUL;
      S_MUL:  if (mul_st.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r <= in_channel;
      z_r  <= in_measurement;
      q_r  <= in_process_noise;
      rn_r <= in_measure_noise;
    end
    if (state_r == S_PREP) begin
      x_r    <= x_cur;
      pp_r   <= pp_sum[WORD_W] ? '1 : pp_sum[WORD_W-1:0];
      diff_r <= {z_r[WORD_W-1], z_r} - {x_cur[WORD_W-1], x_cur};
    end
    if (wr_en) begin
      out_channel_r  <= ch_r;
      out_estimate_r <= est_new;
      out_variance_r <= var_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_estimate    = out_estimate_r;
  assign out_variance    = out_variance_r;

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_range) |=> (state_r == S_READ))
    else $error("accepted item did not start a memory read");

  a_div_owned : assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == S_DIV))
    else $error("divider busy outside its state");

  a_mul_owned : assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.busy |-> (state_r == S_MUL))
    else $error("multiplier busy outside its state");

  a_var_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (kpp <= pp_r))
    else $error("variance correction exceeds predicted variance");

endmodule

### hw/rtl/msk_store.sv
// ----------------------------------------------------------------------------
// msk_store: per-channel filter state
// Estimate and variance memory with a registered read port, plus seen flags.
// ----------------------------------------------------------------------------
module msk_store import msk_pkg::*; #(
  parameter int CHANNELS = 12,
  parameter int CH_W     = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  output msk_entry_t      rd_data,
  output logic            rd_seen,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  msk_entry_t      wr_data
);

  msk_entry_t          mem_r [CHANNELS];
  logic [CHANNELS-1:0] seen_r;
  msk_entry_t          rd_data_r;
  logic                rd_seen_r;

  // The memory has no reset; the seen flag keeps unwritten entries from use.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      rd_seen_r <= 1'b0;
    end else begin
      if (wr_en) begin
        seen_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_seen_r <= seen_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_seen = rd_seen_r;

endmodule

### hw/rtl/msk_div.sv
// ----------------------------------------------------------------------------
// msk_div: bit-serial gain divider
// Restoring division K = floor(Pp * 2^F / (Pp + R)), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module msk_div import msk_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_W-1:0]    pp,
  input  logic [WORD_W:0]      den,
  output logic [FRAC_BITS:0]   gain,
  output unit_status_t         status
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [WORD_W+1:0]  rem_r;
  logic [WORD_W:0]    den_r;
  logic [FRAC_BITS:0] quo_r;
  logic               zero_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [WORD_W+1:0]  trial;
  logic [WORD_W+1:0]  trial_sub;
  logic               trial_ge;

  // Since Pp <= Pp + R, the first step only yields the integer bit, which is
  // set exactly when R is zero; later steps shift the remainder left.
  always_comb begin
    trial     = (cnt_r == '0) ? rem_r : {rem_r[WORD_W:0], 1'b0};
    trial_ge  = (trial >= {1'b0, den_r});
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(FRAC_BITS));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, pp};
      den_r  <= den;
      zero_r <= (den == '0);
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= trial_ge ? trial_sub : trial;
      quo_r <= {quo_r[FRAC_BITS-1:0], trial_ge};
    end
  end

  assign gain   = zero_r ? '0 : quo_r;
  assign status = '{busy: busy_r, done: done_r};

endmodule

### hw/rtl/msk_mul.sv
// ----------------------------------------------------------------------------
// msk_mul: bit-serial gain multiplier
// Forms floor(diff*K / 2^F) and floor(K*Pp / 2^F) one gain bit a cycle.
// ----------------------------------------------------------------------------
module msk_mul import msk_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [FRAC_BITS:0]       gain,
  input  logic signed [WORD_W:0]   diff,
  input  logic [WORD_W-1:0]        pp,
  output logic signed [WORD_W+1:0] corr,
  output logic [WORD_W-1:0]        kpp,
  output unit_status_t             status
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic [FRAC_BITS:0]       gain_r;
  logic signed [WORD_W:0]   diff_r;
  logic [WORD_W-1:0]        pp_r;
  logic signed [WORD_W+1:0] acc_d_r;
  logic [WORD_W-1:0]        acc_p_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r;
  logic                     done_r;

  logic signed [WORD_W+2:0] sum_d;
  logic [WORD_W:0]          sum_p;

  // Gain bits go in from the bottom; each step adds and halves, dropping the
  // bit shifted out, which leaves the floor of the scaled product.
  always_comb begin
    sum_d = {{2{acc_d_r[WORD_W+1]}}, acc_d_r[WORD_W:0]}
          + (gain_r[0] ? {{2{diff_r[WORD_W]}}, diff_r} : '0);
    sum_p = {1'b0, acc_p_r} + (gain_r[0] ? {1'b0, pp_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(FRAC_BITS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gain_r  <= gain;
      diff_r  <= diff;
      pp_r    <= pp;
      acc_d_r <= '0;
      acc_p_r <= '0;
    end else if (busy_r) begin
      gain_r  <= {1'b0, gain_r[FRAC_BITS:1]};
      acc_d_r <= sum_d[WORD_W+2:1];
      acc_p_r <= sum_p[WORD_W:1];
    end
  end

  // The remaining gain bit is the integer one; when set, the gain is exactly
  // one and all fraction bits were zero.
  assign corr   = gain_r[0] ? {diff_r[WORD_W], diff_r} : acc_d_r;
  assign kpp    = gain_r[0] ? pp_r : acc_p_r;
  assign status = '{busy: busy_r, done: done_r};

endmodule

### sim/tb_multichannel_scalar_kalman.sv
// ----------------------------------------------------------------------------
// tb_multichannel_scalar_kalman: self-checking bench of the channel Kalman filter
// Items go in through a valid/stall sender. Each accepted item on a used channel
// updates a private copy of the per-channel estimate and variance, and that copy
// supplies the expected result. Every result is compared with the oldest expected one.
// Random idling runs on both sides. One long output hold makes the block fill
// up and stall its input.
// ----------------------------------------------------------------------------
module tb_multichannel_scalar_kalman;
  import msk_pkg::*;

  localparam int NUM_CH = 12;
  localparam int FRAC = 16;
  localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 2 * FRAC + 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic [CHAN_W-1:0]        chan;
    logic signed [WORD_W-1:0] est;
    logic [WORD_W-1:0]        pvar;
  } filter_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CHAN_W-1:0]        in_channel = '0;
  logic signed [WORD_W-1:0] in_measurement = '0;
  logic [WORD_W-1:0]        in_process_noise = '0;
  logic [WORD_W-1:0]        in_measure_noise = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CHAN_W-1:0]        out_channel_out;
  logic signed [WORD_W-1:0] out_estimate;
  logic [WORD_W-1:0]        out_variance;

  // Private copy of the filter state.
  logic signed [WORD_W-1:0] chan_est [NUM_CH];
  logic [WORD_W-1:0]        chan_var [NUM_CH];
  bit                       chan_seen [NUM_CH];

  filter_result_t filtered_q[$];

  bit          tx_idling;
  bit          rx_idling;
  int unsigned hold_token = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned items_dropped = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;

  multichannel_scalar_kalman #(
    .CHANNELS (NUM_CH),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_measurement  (in_measurement),
    .in_process_noise(in_process_noise),
    .in_measure_noise(in_measure_noise),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel_out (out_channel_out),
    .out_estimate    (out_estimate),
    .out_variance    (out_variance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, filtered_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a long hold when one is requested, otherwise short random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_token != hold_served) begin
      hold_served <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (rx_idling && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: ch %0d est %h var %h",
                   out_channel_out, out_estimate, out_variance);
      end else begin
        want = filtered_q.pop_front();
        if (out_channel_out !== want.chan || out_estimate !== want.est ||
            out_variance !== want.pvar) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Result %0d differs: expected ch %0d est %h var %h, ",
                      "got ch %0d est %h var %h"},
                     results_checked, want.chan, want.est, want.pvar,
                     out_channel_out, out_estimate, out_variance);
        end
      end
    end
  end

  // Updates the private filter state for one item and queues the result it gives; items on unused channels are counted.
  function automatic void kalman_update(input logic [CHAN_W-1:0] ch,
                                        input logic signed [WORD_W-1:0] z,
                                        input logic [WORD_W-1:0] q,
                                        input logic [WORD_W-1:0] r);
    longint unsigned pp;
    longint unsigned den;
    longint unsigned gain;
    longint unsigned kpp;
    longint          diff;
    longint          corr;
    longint          xnew;
    filter_result_t  res;
    if (ch >= NUM_CH) begin
      items_dropped++;
      return;
    end
    if (!chan_seen[ch]) begin
      chan_est[ch] = z;
      chan_var[ch] = ONE;
      chan_seen[ch] = 1'b1;
    end
    pp = {32'd0, chan_var[ch]} + {32'd0, q};
    if (pp > 64'h0000_0000_FFFF_FFFF)
      pp = 64'h0000_0000_FFFF_FFFF;
    den = pp + {32'd0, r};
    gain = (den == 0) ? 64'd0 : (pp << FRAC) / den;
    if (gain > (64'd1 << FRAC))
      gain = 64'd1 << FRAC;
    diff = longint'(z) - longint'(chan_est[ch]);
    corr = (diff * longint'(gain)) >>> FRAC;
    xnew = longint'(chan_est[ch]) + corr;
    if (xnew > longint'(32'sh7FFF_FFFF))
      xnew = longint'(32'sh7FFF_FFFF);
    else if (xnew < longint'(32'sh8000_0000))
      xnew = longint'(32'sh8000_0000);
    chan_est[ch] = xnew[WORD_W-1:0];
    kpp = (gain * pp) >> FRAC;
    chan_var[ch] = 32'(pp - kpp);
    res.chan = ch;
    res.est = chan_est[ch];
    res.pvar = chan_var[ch];
    filtered_q.push_back(res);
  endfunction

  // Must be called at a rising edge; returns at the edge that takes the item.
  task automatic send_item(input logic [CHAN_W-1:0] ch, input logic signed [WORD_W-1:0] z,
                           input logic [WORD_W-1:0] q, input logic [WORD_W-1:0] r);
    int unsigned gap;
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_measurement <= z;
    in_process_noise <= q;
    in_measure_noise <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    kalman_update(ch, z, q, r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_noise();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return $urandom_range(0, 255);
      3, 4:    return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // Mostly samples near the current estimate, so the filter tracks a signal.
  function automatic logic signed [WORD_W-1:0] pick_measurement(input int ch);
    int delta;
    delta = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    case ($urandom_range(0, 9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2, 3:    return $urandom;
      default: return (ch < NUM_CH && chan_seen[ch]) ? chan_est[ch] + delta : $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned n, input bit allow_unused);
    int unsigned kept;
    logic [CHAN_W-1:0] ch;
    kept = 0;
    while (kept < n) begin
      if (allow_unused && $urandom_range(0, 15) == 0)
        ch = CHAN_W'($urandom_range(NUM_CH, 2 ** CHAN_W - 1));
      else
        ch = CHAN_W'($urandom_range(0, NUM_CH - 1));
      send_item(ch, pick_measurement(ch), pick_noise(), pick_noise());
      if (ch < NUM_CH)
        kept++;
    end
  endtask

  task automatic test_first_samples();
    send_item(4'd0, 32'sh0003_0000, '0, '0);
    send_item(4'd11, S32_MAX, '0, ONE);
    send_item(4'd5, S32_MIN, ALL_ONES, ALL_ONES);
    send_item(4'd1, -32'sd1, ONE, ONE);
    wait_drained();
  endtask

  // Channels past the last filter must vanish without disturbing the others.
  task automatic test_unused_channels();
    send_item(4'd12, $urandom, $urandom, $urandom);
    send_item(4'd15, $urandom, $urandom, $urandom);
    send_item(4'd0, 32'sh0001_8000, ONE, ONE);
    wait_drained();
  endtask

  task automatic test_zero_gain();
    send_item(4'd6, 32'sh1234_5678, '0, '0);
    // The variance is now zero, so zero noise leaves a zero denominator.
    send_item(4'd6, 32'sh0765_4321, '0, '0);
    send_item(4'd6, 32'sh0765_4321, '0, ALL_ONES);
    send_item(4'd6, 32'sh0765_4321, ONE, '0);
    wait_drained();
  endtask

  task automatic test_extremes();
    send_item(4'd11, S32_MIN, ONE, '0);
    send_item(4'd11, S32_MAX, ALL_ONES, '0);
    send_item(4'd5, S32_MAX, ALL_ONES, 32'd1);
    send_item(4'd2, '0, ALL_ONES, ALL_ONES);
    send_item(4'd3, 32'sh0000_FFFF, 32'd1, S32_MAX);
    send_item(4'd4, 32'sh5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(4'd4, 32'shAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(4'd10, S32_MIN, ALL_ONES, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random(1000, 1'b1);
    wait_drained();
  endtask

  // The receiver holds off for many cycles while items keep coming.
  task automatic test_output_hold();
    hold_token++;
    run_random(30, 1'b0);
    wait_drained();
  endtask

  task automatic test_streaming();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    run_random(420, 1'b1);
    wait_drained();
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan_est[c] = '0;
      chan_var[c] = '0;
      chan_seen[c] = 1'b0;
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_samples();
    test_unused_channels();
    test_zero_gain();
    test_extremes();
    test_random_traffic();
    test_output_hold();
    test_streaming();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d on unused channels); checked %0d filter results.",
             items_sent, items_dropped, results_checked);
    $display("Covered first samples, zero and full gain, saturated noise, output hold ",
             "and back-to-back streaming.");
    if (mismatches == 0 && filtered_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
